// ===== hdl/rmc_pkg.sv =====
// Shared types, codes and default sizes for the register machine core.
// Used by register_machine_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rmc_pkg;

  // Default sizes, handed to the top level parameters
  localparam int MEM_BYTES_DEF  = 65536;
  localparam int PAGE_BYTES_DEF = 256;
  localparam int NUM_PAGES_DEF  = 256;
  localparam int NUM_REGS_DEF   = 16;

  // Transaction modes
  localparam logic [1:0] MODE_EXEC    = 2'd0;
  localparam logic [1:0] MODE_HOST_WR = 2'd1;
  localparam logic [1:0] MODE_PAGE    = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_HALT  = 2'd1;
  localparam logic [1:0] ST_FAULT = 2'd2;

  // Page rights bits
  localparam logic [3:0] PR_READ    = 4'h1;
  localparam logic [3:0] PR_WRITE   = 4'h2;
  localparam logic [3:0] PR_EXEC    = 4'h4;
  localparam logic [3:0] PR_PRESENT = 4'h8;

  // Configuration register indexes
  localparam logic CFG_HEAP_BASE = 1'b0;
  localparam logic CFG_HEAP_SIZE = 1'b1;

  localparam logic [15:0] HEAP_BASE_RST = 16'd16384;
  localparam logic [16:0] HEAP_SIZE_RST = 17'd32768;

  // Opcodes
  localparam logic [7:0] OP_ADD     = 8'd0;
  localparam logic [7:0] OP_SUB     = 8'd1;
  localparam logic [7:0] OP_MUL     = 8'd2;
  localparam logic [7:0] OP_DIV     = 8'd3;
  localparam logic [7:0] OP_MOD     = 8'd4;
  localparam logic [7:0] OP_NEG     = 8'd5;
  localparam logic [7:0] OP_AND     = 8'd6;
  localparam logic [7:0] OP_OR      = 8'd7;
  localparam logic [7:0] OP_XOR     = 8'd8;
  localparam logic [7:0] OP_NOT     = 8'd9;
  localparam logic [7:0] OP_SHL     = 8'd10;
  localparam logic [7:0] OP_SHR     = 8'd11;
  localparam logic [7:0] OP_LOAD    = 8'd12;
  localparam logic [7:0] OP_STORE   = 8'd13;
  localparam logic [7:0] OP_LOADI   = 8'd14;
  localparam logic [7:0] OP_LOADB   = 8'd15;
  localparam logic [7:0] OP_STOREB  = 8'd16;
  localparam logic [7:0] OP_MOVE    = 8'd17;
  localparam logic [7:0] OP_CMP     = 8'd18;
  localparam logic [7:0] OP_TEST    = 8'd19;
  localparam logic [7:0] OP_SLT     = 8'd20;
  localparam logic [7:0] OP_SLE     = 8'd21;
  localparam logic [7:0] OP_SEQ     = 8'd22;
  localparam logic [7:0] OP_SNE     = 8'd23;
  localparam logic [7:0] OP_JMP     = 8'd24;
  localparam logic [7:0] OP_JZ      = 8'd25;
  localparam logic [7:0] OP_JNZ     = 8'd26;
  localparam logic [7:0] OP_JC      = 8'd27;
  localparam logic [7:0] OP_JNC     = 8'd28;
  localparam logic [7:0] OP_CALL    = 8'd29;
  localparam logic [7:0] OP_RET     = 8'd30;
  localparam logic [7:0] OP_SYSCALL = 8'd31;
  localparam logic [7:0] OP_HALT    = 8'd32;

  // System call numbers
  localparam logic [31:0] SYS_EXIT    = 32'd0;
  localparam logic [31:0] SYS_PRINT   = 32'd1;
  localparam logic [31:0] SYS_READ    = 32'd2;
  localparam logic [31:0] SYS_TIME    = 32'd3;
  localparam logic [31:0] SYS_SLEEP   = 32'd4;
  localparam logic [31:0] SYS_ALLOC   = 32'd5;
  localparam logic [31:0] SYS_FREE    = 32'd6;
  localparam logic [31:0] SYS_FILE_LO = 32'd7;
  localparam logic [31:0] SYS_FILE_HI = 32'd10;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] address;
    logic [31:0] data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] pc_after;
    logic [3:0]  flag_bits;
    logic [31:0] exit_value;
    logic [31:0] written_value;
  } out_item_t;

  // Rights of a page after reset, from its first byte address
  function automatic logic [3:0] page_rst_rights(input logic [32:0] st,
                                                 input logic [32:0] mem_bytes);
    logic [3:0] v;
    v = 4'h0;
    if (st < 33'(16 * 1024)) begin
      v = PR_READ | PR_EXEC | PR_PRESENT;
    end else if (st < 33'd49152) begin
      v = PR_READ | PR_WRITE | PR_PRESENT;
    end else if (st < mem_bytes && (st + 33'd8192) >= mem_bytes) begin
      v = PR_READ | PR_WRITE | PR_PRESENT;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/register_machine_core.sv =====
// Register machine core: sequencer, shared ALU, page check walker, divider.
// Depends on rmc_pkg and rmc_ram.
//
//  channel  | ports                              | handshake
//  ---------+------------------------------------+-------------------------------
//  input    | start, busy, in_item               | taken when start & !busy
//  result   | out_valid, out_result              | one-cycle strobe, no back-off
//  config   | psel penable pwrite paddr pwdata   | APB write, pready tied high
//           | prdata pready                      |
//
// One transaction at a time. Page and mode-3 transactions and halted steps
// strobe their result in the cycle after acceptance; a host write runs a span
// check, writes its word byte by byte and then strobes. An execute step runs a
// span check page by page, fetches its word byte by byte, then decodes, reads
// registers, executes and finishes before its strobe. A memory access adds a
// span check and a byte-by-byte read plus write-back, or a byte-by-byte write;
// divide and modulo pass through the shift divider; console calls add a span
// check. After reset a clearing pass zeroes memory and registers and loads
// page rights; busy stays high. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module register_machine_core #(
  parameter int MEM_BYTES  = rmc_pkg::MEM_BYTES_DEF,
  parameter int PAGE_BYTES = rmc_pkg::PAGE_BYTES_DEF,
  parameter int NUM_PAGES  = rmc_pkg::NUM_PAGES_DEF,
  parameter int NUM_REGS   = rmc_pkg::NUM_REGS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire rmc_pkg::in_item_t in_item,
  output logic                   out_valid,
  output rmc_pkg::out_item_t     out_result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  import rmc_pkg::*;

  localparam int MAW     = $clog2(MEM_BYTES);
  localparam int PS      = $clog2(PAGE_BYTES);
  localparam int PGW     = MAW - PS;
  localparam int PIW     = $clog2(NUM_PAGES);
  localparam int RIW     = $clog2(NUM_REGS);
  localparam int CLR_LEN = (MEM_BYTES > NUM_PAGES) ? MEM_BYTES : NUM_PAGES;
  localparam int CLW     = $clog2(CLR_LEN) + 1;

  // Sequencer states
  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_CHK0  = 5'd2;
  localparam logic [4:0] S_CHKRD = 5'd3;
  localparam logic [4:0] S_CHKEV = 5'd4;
  localparam logic [4:0] S_MRDA  = 5'd5;
  localparam logic [4:0] S_MRDD  = 5'd6;
  localparam logic [4:0] S_MWR   = 5'd7;
  localparam logic [4:0] S_FETCH = 5'd8;
  localparam logic [4:0] S_DEC   = 5'd9;
  localparam logic [4:0] S_REG   = 5'd10;
  localparam logic [4:0] S_EXE   = 5'd11;
  localparam logic [4:0] S_DIV   = 5'd12;
  localparam logic [4:0] S_DIVWB = 5'd13;
  localparam logic [4:0] S_MEMOP = 5'd14;
  localparam logic [4:0] S_LDWB  = 5'd15;
  localparam logic [4:0] S_SYSCK = 5'd16;
  localparam logic [4:0] S_HOST  = 5'd17;
  localparam logic [4:0] S_FIN   = 5'd18;
  localparam logic [4:0] S_RESP  = 5'd19;

  // Architectural state
  logic [31:0] pc_r, pc_nxt;
  logic [31:0] sp_r, sp_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic        halted_r, halted_nxt;
  logic [31:0] heap_used_r, heap_used_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [31:0] exit_r, exit_nxt;
  logic [15:0] heap_base_r, heap_base_nxt;
  logic [16:0] heap_size_r, heap_size_nxt;

  // Control
  logic [4:0]     state_r, state_nxt;
  logic [4:0]     ret_r, ret_nxt;
  logic [CLW-1:0] clr_r, clr_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     status_r, status_nxt;
  logic [31:0]    wrv_r, wrv_nxt;
  logic           fault_r, fault_nxt;
  logic           chk_ok_r, chk_ok_nxt;

  // Working registers
  logic [31:0]    ins_r, ins_nxt;
  logic [31:0]    old_pc_r, old_pc_nxt;
  logic [31:0]    a_r, a_nxt;
  logic [31:0]    b_r, b_nxt;
  logic [31:0]    c_r, c_nxt;
  logic [31:0]    word_r, word_nxt;
  logic [MAW-1:0] ma_r, ma_nxt;
  logic [2:0]     mcnt_r, mcnt_nxt;
  logic [2:0]     mlen_r, mlen_nxt;
  logic [1:0]     rk_r, rk_nxt;
  logic [4:0]     div_cnt_r, div_cnt_nxt;
  logic [31:0]    chk_addr_r, chk_addr_nxt;
  logic [31:0]    chk_size_r, chk_size_nxt;
  logic [3:0]     chk_need_r, chk_need_nxt;
  logic [PGW:0]   pg_r, pg_nxt;
  logic [PGW-1:0] last_r, last_nxt;

  // Memory ports
  logic           mem_we;
  logic [MAW-1:0] mem_waddr, mem_raddr;
  logic [7:0]     mem_wdata, mem_rdata;
  logic           pg_we;
  logic [PIW-1:0] pg_waddr, pg_raddr;
  logic [3:0]     pg_wdata, pg_rdata;
  logic           rf_we;
  logic [RIW-1:0] rf_waddr, rf_raddr;
  logic [31:0]    rf_wdata, rf_rdata;

  // Sub-sequence launch requests
  logic           chk_go;
  logic [31:0]    chk_go_addr, chk_go_size;
  logic [3:0]     chk_go_need;
  logic [4:0]     chk_go_ret;
  logic           mem_go, mem_go_wr;
  logic [MAW-1:0] mem_go_addr;
  logic [2:0]     mem_go_len;
  logic [31:0]    mem_go_data;
  logic [4:0]     mem_go_ret;
  logic           rw_go;
  logic [3:0]     rw_idx;
  logic [31:0]    rw_val;

  // Decode and shared datapath
  logic [7:0]  op;
  logic [3:0]  rd_idx;
  logic [31:0] tgt, imm;
  logic [32:0] sum33, diff33, end33, end_m1, used_sum, round33, rem_sh;
  logic [63:0] prod;
  logic [31:0] clr_ext, pg_ext, addr_ext;
  logic [3:0]  ridx_issue, ridx_cap;
  logic        cap_ok;
  logic [31:0] res;

  rmc_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  rmc_ram #(.WIDTH(4), .DEPTH(NUM_PAGES)) u_pages (
    .clk(clk), .we(pg_we), .waddr(pg_waddr), .wdata(pg_wdata),
    .raddr(pg_raddr), .rdata(pg_rdata)
  );

  rmc_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_regs (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata)
  );

  function automatic logic [3:0] mk_flags(input logic [31:0] r, input logic c,
                                          input logic v);
    return {v, c, r[31], (r == 32'd0)};
  endfunction

  // Register read order: rs1, rs2, rd; a system call reads r1, r2, r0
  function automatic logic [3:0] slot_idx(input logic [31:0] ins, input logic [1:0] k);
    logic [3:0] idx;
    idx = 4'd0;
    if (ins[31:24] == OP_SYSCALL) begin
      case (k)
        2'd0:    idx = 4'd1;
        2'd1:    idx = 4'd2;
        default: idx = 4'd0;
      endcase
    end else begin
      case (k)
        2'd0:    idx = ins[11:8];
        2'd1:    idx = ins[3:0];
        default: idx = ins[19:16];
      endcase
    end
    return idx;
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_result = {status_r, pc_r, flags_r, exit_r, wrv_r};
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == CFG_HEAP_SIZE) ? {15'd0, heap_size_r}
                                                  : {16'd0, heap_base_r};

  // Decode and shared arithmetic
  assign op       = ins_r[31:24];
  assign rd_idx   = ins_r[19:16];
  assign tgt      = {{8{ins_r[23]}}, ins_r[23:0]};
  assign imm      = {{16{ins_r[15]}}, ins_r[15:0]};
  assign sum33    = {1'b0, a_r} + {1'b0, b_r};
  assign diff33   = {1'b0, a_r} - {1'b0, b_r};
  assign prod     = a_r * b_r;
  assign end33    = {1'b0, chk_addr_r} + {1'b0, chk_size_r};
  assign end_m1   = end33 - 33'd1;
  assign used_sum = {1'b0, heap_used_r} + {1'b0, a_r};
  assign round33  = {1'b0, a_r} + 33'd3;
  assign rem_sh   = {c_r, a_r[31]};
  assign clr_ext  = 32'(clr_r);
  assign pg_ext   = 32'(pg_r);
  assign addr_ext = 32'(in_item.address);
  assign ridx_issue = slot_idx(ins_r, rk_r);
  assign ridx_cap   = slot_idx(ins_r, rk_r - 2'd1);
  assign cap_ok     = ({1'b0, ridx_cap} < 5'(NUM_REGS));

  // Sequencer
  always_comb begin
    pc_nxt        = pc_r;
    sp_nxt        = sp_r;
    flags_nxt     = flags_r;
    halted_nxt    = halted_r;
    heap_used_nxt = heap_used_r;
    tick_nxt      = tick_r;
    exit_nxt      = exit_r;
    heap_base_nxt = heap_base_r;
    heap_size_nxt = heap_size_r;
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    wrv_nxt       = wrv_r;
    fault_nxt     = fault_r;
    chk_ok_nxt    = chk_ok_r;
    ins_nxt       = ins_r;
    old_pc_nxt    = old_pc_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    word_nxt      = word_r;
    ma_nxt        = ma_r;
    mcnt_nxt      = mcnt_r;
    mlen_nxt      = mlen_r;
    rk_nxt        = rk_r;
    div_cnt_nxt   = div_cnt_r;
    chk_addr_nxt  = chk_addr_r;
    chk_size_nxt  = chk_size_r;
    chk_need_nxt  = chk_need_r;
    pg_nxt        = pg_r;
    last_nxt      = last_r;

    mem_we    = 1'b0;
    mem_waddr = ma_r + MAW'(mcnt_r);
    mem_wdata = word_r[7:0];
    mem_raddr = ma_r + MAW'(mcnt_r);
    pg_we     = 1'b0;
    pg_waddr  = addr_ext[PIW-1:0];
    pg_wdata  = in_item.data[3:0];
    pg_raddr  = pg_ext[PIW-1:0];
    rf_we     = 1'b0;
    rf_waddr  = rw_idx[RIW-1:0];
    rf_wdata  = rw_val;
    rf_raddr  = ridx_issue[RIW-1:0];

    chk_go      = 1'b0;
    chk_go_addr = 32'd0;
    chk_go_size = 32'd4;
    chk_go_need = PR_READ;
    chk_go_ret  = S_IDLE;
    mem_go      = 1'b0;
    mem_go_wr   = 1'b0;
    mem_go_addr = chk_addr_r[MAW-1:0];
    mem_go_len  = 3'd4;
    mem_go_data = c_r;
    mem_go_ret  = S_FIN;
    rw_go       = 1'b0;
    rw_idx      = rd_idx;
    rw_val      = 32'd0;
    res         = 32'd0;

    // configuration writes
    if (psel && penable && pwrite) begin
      if (paddr[2] == CFG_HEAP_SIZE) begin
        heap_size_nxt = pwdata[16:0];
      end else begin
        heap_base_nxt = pwdata[15:0];
      end
    end

    case (state_r)
      // clearing pass after reset
      S_CLR: begin
        mem_we    = (clr_ext < 32'(MEM_BYTES));
        mem_waddr = clr_ext[MAW-1:0];
        mem_wdata = 8'd0;
        pg_we     = (clr_ext < 32'(NUM_PAGES));
        pg_waddr  = clr_ext[PIW-1:0];
        pg_wdata  = page_rst_rights({1'b0, clr_ext} << PS, 33'(MEM_BYTES));
        rf_we     = (clr_ext < 32'(NUM_REGS));
        rf_waddr  = clr_ext[RIW-1:0];
        rf_wdata  = 32'd0;
        clr_nxt   = clr_r + CLW'(1);
        if (clr_ext == 32'(CLR_LEN - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          wrv_nxt    = 32'd0;
          fault_nxt  = 1'b0;
          status_nxt = ST_OK;
          case (in_item.mode)
            MODE_EXEC: begin
              if (halted_r) begin
                status_nxt    = ST_HALT;
                out_valid_nxt = 1'b1;
              end else begin
                old_pc_nxt  = pc_r;
                chk_go      = 1'b1;
                chk_go_addr = pc_r;
                chk_go_need = PR_READ | PR_EXEC;
                chk_go_ret  = S_FETCH;
              end
            end
            MODE_HOST_WR: begin
              c_nxt       = in_item.data;
              chk_go      = 1'b1;
              chk_go_addr = addr_ext;
              chk_go_need = PR_PRESENT;
              chk_go_ret  = S_HOST;
            end
            MODE_PAGE: begin
              if (addr_ext < 32'(NUM_PAGES)) begin
                pg_we = 1'b1;
              end else begin
                status_nxt = ST_FAULT;
              end
              out_valid_nxt = 1'b1;
            end
            default: begin
              status_nxt    = ST_FAULT;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // span check: bounds, then each page read and evaluated in turn
      S_CHK0: begin
        if (end33 > 33'(MEM_BYTES)) begin
          chk_ok_nxt = 1'b0;
          state_nxt  = ret_r;
        end else if (chk_size_r == 32'd0) begin
          chk_ok_nxt = 1'b1;
          state_nxt  = ret_r;
        end else begin
          pg_nxt    = {1'b0, chk_addr_r[MAW-1:PS]};
          last_nxt  = end_m1[MAW-1:PS];
          state_nxt = S_CHKRD;
        end
      end
      S_CHKRD: begin
        if (pg_r > {1'b0, last_r}) begin
          chk_ok_nxt = 1'b1;
          state_nxt  = ret_r;
        end else if (pg_ext >= 32'(NUM_PAGES)) begin
          chk_ok_nxt = 1'b0;
          state_nxt  = ret_r;
        end else begin
          state_nxt = S_CHKEV;
        end
      end
      S_CHKEV: begin
        if (!pg_rdata[3] || ((pg_rdata & chk_need_r) != chk_need_r)) begin
          chk_ok_nxt = 1'b0;
          state_nxt  = ret_r;
        end else begin
          pg_nxt    = pg_r + (PGW+1)'(1);
          state_nxt = S_CHKRD;
        end
      end

      // byte loops, little-endian
      S_MRDA: begin
        state_nxt = S_MRDD;
      end
      S_MRDD: begin
        word_nxt = {mem_rdata, word_r[31:8]};
        mcnt_nxt = mcnt_r + 3'd1;
        state_nxt = (mcnt_r + 3'd1 == mlen_r) ? ret_r : S_MRDA;
      end
      S_MWR: begin
        mem_we   = 1'b1;
        word_nxt = {8'd0, word_r[31:8]};
        mcnt_nxt = mcnt_r + 3'd1;
        if (mcnt_r + 3'd1 == mlen_r) begin
          state_nxt = ret_r;
        end
      end

      S_FETCH: begin
        if (!chk_ok_r) begin
          status_nxt    = ST_FAULT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          mem_go      = 1'b1;
          mem_go_addr = pc_r[MAW-1:0];
          mem_go_ret  = S_DEC;
        end
      end
      S_DEC: begin
        ins_nxt   = word_r;
        rk_nxt    = 2'd0;
        state_nxt = S_REG;
      end

      // three register reads, each read's data arriving in the cycle after its address
      S_REG: begin
        case (rk_r)
          2'd1:    a_nxt = cap_ok ? rf_rdata : 32'd0;
          2'd2:    b_nxt = cap_ok ? rf_rdata : 32'd0;
          2'd3:    c_nxt = cap_ok ? rf_rdata : 32'd0;
          default: ;
        endcase
        rk_nxt = rk_r + 2'd1;
        if (rk_r == 2'd3) begin
          state_nxt = S_EXE;
        end
      end

      S_EXE: begin
        state_nxt = S_FIN;
        case (op)
          OP_ADD: begin
            res = sum33[31:0];
            rw_go = 1'b1; rw_val = res;
            flags_nxt = mk_flags(res, sum33[32],
                                 (a_r[31] ^ res[31]) & (b_r[31] ^ res[31]));
          end
          OP_SUB, OP_CMP: begin
            res = diff33[31:0];
            rw_go = (op == OP_SUB); rw_val = res;
            flags_nxt = mk_flags(res, (a_r < b_r),
                                 (a_r[31] ^ b_r[31]) & (a_r[31] ^ res[31]));
          end
          OP_MUL: begin
            res = prod[31:0];
            rw_go = 1'b1; rw_val = res;
            flags_nxt = mk_flags(res, (prod[63:32] != 32'd0), 1'b0);
          end
          OP_DIV, OP_MOD: begin
            if (b_r == 32'd0) begin
              rw_go     = 1'b1;
              rw_val    = 32'd0;
              fault_nxt = 1'b1;
            end else begin
              c_nxt       = 32'd0;
              div_cnt_nxt = 5'd0;
              state_nxt   = S_DIV;
            end
          end
          OP_NEG, OP_AND, OP_OR, OP_XOR, OP_NOT, OP_SHL, OP_SHR: begin
            case (op)
              OP_NEG:  res = 32'd0 - a_r;
              OP_AND:  res = a_r & b_r;
              OP_OR:   res = a_r | b_r;
              OP_XOR:  res = a_r ^ b_r;
              OP_NOT:  res = ~a_r;
              OP_SHL:  res = a_r << b_r[4:0];
              default: res = a_r >> b_r[4:0];
            endcase
            rw_go = 1'b1; rw_val = res;
            flags_nxt = mk_flags(res, 1'b0, 1'b0);
          end
          OP_TEST: flags_nxt = mk_flags(a_r & b_r, 1'b0, 1'b0);
          OP_LOAD, OP_STORE, OP_LOADB, OP_STOREB: begin
            chk_go      = 1'b1;
            chk_go_addr = sum33[31:0];
            chk_go_size = (op == OP_LOAD || op == OP_STORE) ? 32'd4 : 32'd1;
            chk_go_need = (op == OP_LOAD || op == OP_LOADB) ? PR_READ : PR_WRITE;
            chk_go_ret  = S_MEMOP;
          end
          OP_LOADI: begin rw_go = 1'b1; rw_val = imm; end
          OP_MOVE:  begin rw_go = 1'b1; rw_val = a_r; end
          OP_SLT:   begin rw_go = 1'b1; rw_val = {31'd0, $signed(a_r) < $signed(b_r)}; end
          OP_SLE:   begin rw_go = 1'b1; rw_val = {31'd0, $signed(a_r) <= $signed(b_r)}; end
          OP_SEQ:   begin rw_go = 1'b1; rw_val = {31'd0, a_r == b_r}; end
          OP_SNE:   begin rw_go = 1'b1; rw_val = {31'd0, a_r != b_r}; end
          OP_JMP:   pc_nxt = tgt;
          OP_JZ:    if (flags_r[0])  pc_nxt = tgt;
          OP_JNZ:   if (!flags_r[0]) pc_nxt = tgt;
          OP_JC:    if (flags_r[2])  pc_nxt = tgt;
          OP_JNC:   if (!flags_r[2]) pc_nxt = tgt;
          OP_CALL: begin
            sp_nxt      = sp_r - 32'd4;
            chk_go      = 1'b1;
            chk_go_addr = sp_r - 32'd4;
            chk_go_need = PR_WRITE;
            chk_go_ret  = S_MEMOP;
          end
          OP_RET: begin
            chk_go      = 1'b1;
            chk_go_addr = sp_r;
            chk_go_need = PR_READ;
            chk_go_ret  = S_MEMOP;
          end
          OP_SYSCALL: begin
            rw_idx = 4'd0;
            case (c_r)
              SYS_EXIT: begin
                exit_nxt   = a_r;
                halted_nxt = 1'b1;
              end
              SYS_PRINT, SYS_READ: begin
                chk_go      = 1'b1;
                chk_go_addr = a_r;
                chk_go_size = b_r;
                chk_go_need = (c_r == SYS_PRINT) ? PR_READ : PR_WRITE;
                chk_go_ret  = S_SYSCK;
              end
              SYS_TIME:  begin rw_go = 1'b1; rw_val = tick_r; end
              SYS_SLEEP: tick_nxt = tick_r + a_r;
              SYS_ALLOC: begin
                rw_go = 1'b1;
                if (used_sum > {16'd0, heap_size_r}) begin
                  rw_val = 32'd0;
                end else begin
                  rw_val        = {16'd0, heap_base_r} + heap_used_r;
                  heap_used_nxt = heap_used_r + {round33[31:2], 2'b00};
                end
              end
              SYS_FREE: begin rw_go = 1'b1; rw_val = 32'd0; end
              default: begin
                // file stubs answer all ones; unknown numbers also fault
                rw_go  = 1'b1;
                rw_val = 32'hFFFF_FFFF;
                if (!(c_r inside {[SYS_FILE_LO:SYS_FILE_HI]})) begin
                  fault_nxt = 1'b1;
                end
              end
            endcase
          end
          OP_HALT: halted_nxt = 1'b1;
          default: fault_nxt = 1'b1;
        endcase
      end

      // restoring divider: quotient shifts through a_r, remainder in c_r
      S_DIV: begin
        if (rem_sh >= {1'b0, b_r}) begin
          c_nxt = 32'(rem_sh - {1'b0, b_r});
          a_nxt = {a_r[30:0], 1'b1};
        end else begin
          c_nxt = rem_sh[31:0];
          a_nxt = {a_r[30:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + 5'd1;
        if (div_cnt_r == 5'd31) begin
          state_nxt = S_DIVWB;
        end
      end
      S_DIVWB: begin
        res       = (op == OP_DIV) ? a_r : c_r;
        rw_go     = 1'b1;
        rw_val    = res;
        flags_nxt = mk_flags(res, 1'b0, 1'b0);
        state_nxt = S_FIN;
      end

      S_MEMOP: begin
        state_nxt = S_FIN;
        if (!chk_ok_r) begin
          fault_nxt = 1'b1;
        end else begin
          case (op)
            OP_LOAD, OP_RET: begin
              mem_go = 1'b1; mem_go_ret = S_LDWB;
            end
            OP_LOADB: begin
              mem_go = 1'b1; mem_go_len = 3'd1; mem_go_ret = S_LDWB;
            end
            OP_STORE: begin
              mem_go = 1'b1; mem_go_wr = 1'b1;
            end
            OP_STOREB: begin
              mem_go = 1'b1; mem_go_wr = 1'b1; mem_go_len = 3'd1;
            end
            OP_CALL: begin
              mem_go      = 1'b1;
              mem_go_wr   = 1'b1;
              mem_go_data = pc_r + 32'd4;
              pc_nxt      = tgt;
            end
            default: ;
          endcase
        end
      end
      S_LDWB: begin
        state_nxt = S_FIN;
        case (op)
          OP_LOAD:  begin rw_go = 1'b1; rw_val = word_r; end
          OP_LOADB: begin rw_go = 1'b1; rw_val = {24'd0, word_r[31:24]}; end
          default: begin
            pc_nxt = word_r;
            sp_nxt = sp_r + 32'd4;
          end
        endcase
      end
      S_SYSCK: begin
        rw_go     = 1'b1;
        rw_idx    = 4'd0;
        state_nxt = S_FIN;
        if (!chk_ok_r) begin
          rw_val    = 32'hFFFF_FFFF;
          fault_nxt = 1'b1;
        end else begin
          rw_val = (c_r == SYS_PRINT) ? b_r : 32'd0;
        end
      end

      // host word write
      S_HOST: begin
        if (!chk_ok_r) begin
          status_nxt    = ST_FAULT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          mem_go      = 1'b1;
          mem_go_wr   = 1'b1;
          mem_go_addr = chk_addr_r[MAW-1:0];
          mem_go_ret  = S_RESP;
        end
      end
      S_RESP: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      // end of an executed instruction
      S_FIN: begin
        tick_nxt = tick_r + 32'd1;
        if (pc_r == old_pc_r) begin
          pc_nxt = pc_r + 32'd4;
        end
        status_nxt    = fault_r ? ST_FAULT : (halted_r ? ST_HALT : ST_OK);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // launch a span check
    if (chk_go) begin
      chk_addr_nxt = chk_go_addr;
      chk_size_nxt = chk_go_size;
      chk_need_nxt = chk_go_need;
      ret_nxt      = chk_go_ret;
      state_nxt    = S_CHK0;
    end
    // launch a byte loop
    if (mem_go) begin
      ma_nxt    = mem_go_addr;
      mlen_nxt  = mem_go_len;
      mcnt_nxt  = 3'd0;
      word_nxt  = mem_go_data;
      ret_nxt   = mem_go_ret;
      state_nxt = mem_go_wr ? S_MWR : S_MRDA;
    end
    // register write-back; missing registers ignore writes
    if (rw_go && ({1'b0, rw_idx} < 5'(NUM_REGS))) begin
      rf_we   = 1'b1;
      wrv_nxt = rw_val;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      status_r    <= ST_OK;
      wrv_r       <= 32'd0;
      pc_r        <= 32'd0;
      sp_r        <= 32'(MEM_BYTES - 4);
      flags_r     <= 4'd0;
      halted_r    <= 1'b0;
      heap_used_r <= 32'd0;
      tick_r      <= 32'd0;
      exit_r      <= 32'd0;
      heap_base_r <= HEAP_BASE_RST;
      heap_size_r <= HEAP_SIZE_RST;
      ret_r       <= S_IDLE;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      wrv_r       <= wrv_nxt;
      pc_r        <= pc_nxt;
      sp_r        <= sp_nxt;
      flags_r     <= flags_nxt;
      halted_r    <= halted_nxt;
      heap_used_r <= heap_used_nxt;
      tick_r      <= tick_nxt;
      exit_r      <= exit_nxt;
      heap_base_r <= heap_base_nxt;
      heap_size_r <= heap_size_nxt;
      ret_r       <= ret_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    fault_r    <= fault_nxt;
    chk_ok_r   <= chk_ok_nxt;
    ins_r      <= ins_nxt;
    old_pc_r   <= old_pc_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    word_r     <= word_nxt;
    ma_r       <= ma_nxt;
    mcnt_r     <= mcnt_nxt;
    mlen_r     <= mlen_nxt;
    rk_r       <= rk_nxt;
    div_cnt_r  <= div_cnt_nxt;
    chk_addr_r <= chk_addr_nxt;
    chk_size_r <= chk_size_nxt;
    chk_need_r <= chk_need_nxt;
    pg_r       <= pg_nxt;
    last_r     <= last_nxt;
  end

endmodule

`default_nettype wire
